### rtl/sba_pkg.sv
// shared constants, codes and types for the speech band agc block
// no dependencies; imported by every module of the block
`default_nettype none

package sba_pkg;

   // sample and arithmetic widths
   localparam int SAMPLE_BITS  = 16;
   localparam int STATE_BITS   = 32;
   localparam int COEF_BITS    = 16;
   localparam int TARGET_BITS  = 15;
   localparam int GAIN_BITS    = 18;
   localparam int BOOST_BITS   = 4;
   localparam int ENV_BITS     = SAMPLE_BITS + 1;
   localparam int Q_SHIFT      = 15;
   localparam int MUL_A_BITS   = GAIN_BITS + 1;
   localparam int PROD_BITS    = MUL_A_BITS + STATE_BITS;

   // envelope and gain tracking
   localparam int ATTACK_SHIFT  = 3;
   localparam int RELEASE_SHIFT = 7;
   localparam int GAIN_SHIFT    = 5;
   localparam int ENV_FLOOR     = 100;
   localparam int UNITY_GAIN    = 32768;

   // serial divider, two quotient bits per cycle
   localparam int DIV_NUM_BITS = TARGET_BITS + Q_SHIFT;
   localparam int DIV_DEN_BITS = ENV_BITS - 1;
   localparam int DIV_STEPS    = DIV_NUM_BITS / 2;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

   // configuration port
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 3;

   localparam logic [REG_IDX_BITS-1:0] REG_COEF_B0      = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_COEF_B1      = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_COEF_B2      = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_COEF_A1      = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_COEF_A2      = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_TARGET_LEVEL = 3'd5;
   localparam logic [REG_IDX_BITS-1:0] REG_MAX_GAIN     = 3'd6;
   localparam logic [REG_IDX_BITS-1:0] REG_OUT_BOOST    = 3'd7;

   // register reset values
   localparam logic [COEF_BITS-1:0]   RST_COEF_B0      = 16'd23777;
   localparam logic [COEF_BITS-1:0]   RST_COEF_B1      = 16'd0;
   localparam logic [COEF_BITS-1:0]   RST_COEF_B2      = 16'hA31F;
   localparam logic [COEF_BITS-1:0]   RST_COEF_A1      = 16'hC43E;
   localparam logic [COEF_BITS-1:0]   RST_COEF_A2      = 16'd8989;
   localparam logic [TARGET_BITS-1:0] RST_TARGET_LEVEL = 15'd16384;
   localparam logic [GAIN_BITS-1:0]   RST_MAX_GAIN     = 18'd196608;
   localparam logic [BOOST_BITS-1:0]  RST_OUT_BOOST    = 4'd3;

   // datapath operations
   localparam int OP_BITS = 4;
   localparam logic [OP_BITS-1:0] OP_NOP     = 4'd0;
   localparam logic [OP_BITS-1:0] OP_LOAD    = 4'd1;
   localparam logic [OP_BITS-1:0] OP_M_A1    = 4'd2;
   localparam logic [OP_BITS-1:0] OP_M_A2    = 4'd3;
   localparam logic [OP_BITS-1:0] OP_W       = 4'd4;
   localparam logic [OP_BITS-1:0] OP_M_B0    = 4'd5;
   localparam logic [OP_BITS-1:0] OP_M_B1    = 4'd6;
   localparam logic [OP_BITS-1:0] OP_M_B2    = 4'd7;
   localparam logic [OP_BITS-1:0] OP_BP      = 4'd8;
   localparam logic [OP_BITS-1:0] OP_ENV     = 4'd9;
   localparam logic [OP_BITS-1:0] OP_GAIN    = 4'd10;
   localparam logic [OP_BITS-1:0] OP_M_XG    = 4'd11;
   localparam logic [OP_BITS-1:0] OP_M_BOOST = 4'd12;
   localparam logic [OP_BITS-1:0] OP_OUT     = 4'd13;

   typedef struct packed {
      logic [COEF_BITS-1:0]   coef_b0;
      logic [COEF_BITS-1:0]   coef_b1;
      logic [COEF_BITS-1:0]   coef_b2;
      logic [COEF_BITS-1:0]   coef_a1;
      logic [COEF_BITS-1:0]   coef_a2;
      logic [TARGET_BITS-1:0] target_level;
      logic [GAIN_BITS-1:0]   max_gain;
      logic [BOOST_BITS-1:0]  out_boost;
   } cfg_type;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic               div_start;
   } cmd_type;

   typedef struct packed {
      logic env_above;
      logic div_done;
   } stat_type;

endpackage

`default_nettype wire

### rtl/sba_div.sv
// serial unsigned divider, restoring, two quotient bits per cycle
// depends on sba_pkg
`default_nettype none

module sba_div
   import sba_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [DIV_NUM_BITS-1:0] dividend,
   input  wire logic [DIV_DEN_BITS-1:0] divisor,
   output logic                         done,
   output logic [DIV_NUM_BITS-1:0]      quotient
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_BITS-1:0] rem_ff, rem_in;
   logic [DIV_NUM_BITS-1:0] quo_ff, quo_in;
   logic [DIV_DEN_BITS-1:0] den_ff, den_in;
   logic [DIV_DEN_BITS-1:0] rem_mid, rem_end;
   logic                    q_hi, q_lo;

   // one restoring step: shift in a bit, subtract when it fits
   function automatic logic [DIV_DEN_BITS:0] div_step(
      input logic [DIV_DEN_BITS-1:0] rem,
      input logic                    nbit,
      input logic [DIV_DEN_BITS-1:0] den
   );
      logic [DIV_DEN_BITS:0] trial;
      logic [DIV_DEN_BITS:0] diff;
      trial = {rem, nbit};
      diff  = trial - {1'b0, den};
      if (trial >= {1'b0, den}) begin
         div_step = {1'b1, diff[DIV_DEN_BITS-1:0]};
      end else begin
         div_step = {1'b0, trial[DIV_DEN_BITS-1:0]};
      end
   endfunction

   // two chained steps per cycle
   always_comb begin
      {q_hi, rem_mid} = div_step(rem_ff, quo_ff[DIV_NUM_BITS-1], den_ff);
      {q_lo, rem_end} = div_step(rem_mid, quo_ff[DIV_NUM_BITS-2], den_ff);
   end

   // iteration control
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = DIV_CNT_BITS'(DIV_STEPS - 1);
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = rem_end;
         quo_in = {quo_ff[DIV_NUM_BITS-3:0], q_hi, q_lo};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - DIV_CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### rtl/sba_dpath.sv
// datapath: shared multiplier, biquad accumulator, envelope and gain
// depends on sba_pkg and sba_div
`default_nettype none

module sba_dpath
   import sba_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   input  wire cfg_type                cfg,
   input  wire logic [SAMPLE_BITS-1:0] req_sample_in,
   output stat_type                    stat,
   output logic [SAMPLE_BITS-1:0]      rsp_sample_out
);

   // filter and tracking state
   logic [STATE_BITS-1:0]  d1_ff, d1_in;
   logic [STATE_BITS-1:0]  d2_ff, d2_in;
   logic [ENV_BITS-1:0]    env_ff, env_in;
   logic [GAIN_BITS-1:0]   gain_ff, gain_in;

   // working registers
   logic [SAMPLE_BITS-1:0] x_ff, x_in;
   logic [STATE_BITS-1:0]  acc_ff, acc_in;
   logic [STATE_BITS-1:0]  w_ff, w_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [SAMPLE_BITS-1:0] out_ff, out_in;

   logic signed [MUL_A_BITS-1:0] mul_a;
   logic signed [STATE_BITS-1:0] mul_b;
   logic signed [PROD_BITS-1:0]  mul_p;
   logic [STATE_BITS-1:0]        psh;
   logic [STATE_BITS-1:0]        x_ext;

   logic [SAMPLE_BITS-1:0]       mag;
   logic signed [ENV_BITS:0]     lvl_ext, env_ext, env_diff, env_step, env_new;

   logic [DIV_NUM_BITS-1:0]      quotient;
   logic                         div_done;
   logic [GAIN_BITS-1:0]         want;
   logic signed [GAIN_BITS:0]    gain_diff, gain_step, gain_new;

   logic [PROD_BITS-SAMPLE_BITS:0] prod_top;

   function automatic logic [MUL_A_BITS-1:0] coef_ext(input logic [COEF_BITS-1:0] c);
      coef_ext = {{(MUL_A_BITS-COEF_BITS){c[COEF_BITS-1]}}, c};
   endfunction

   assign x_ext = {{(STATE_BITS-SAMPLE_BITS){x_ff[SAMPLE_BITS-1]}}, x_ff};
   assign psh   = prod_ff[Q_SHIFT+STATE_BITS-1:Q_SHIFT];

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_M_A1: begin
            mul_a = coef_ext(cfg.coef_a1);
            mul_b = d1_ff;
         end
         OP_M_A2: begin
            mul_a = coef_ext(cfg.coef_a2);
            mul_b = d2_ff;
         end
         OP_M_B0: begin
            mul_a = coef_ext(cfg.coef_b0);
            mul_b = w_ff;
         end
         OP_M_B1: begin
            mul_a = coef_ext(cfg.coef_b1);
            mul_b = d1_ff;
         end
         OP_M_B2: begin
            mul_a = coef_ext(cfg.coef_b2);
            mul_b = d2_ff;
         end
         OP_M_XG: begin
            mul_a = {1'b0, gain_ff};
            mul_b = x_ext;
         end
         OP_M_BOOST: begin
            mul_a = {{(MUL_A_BITS-BOOST_BITS){1'b0}}, cfg.out_boost};
            mul_b = psh;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // envelope follower on the truncated filter magnitude
   always_comb begin
      mag      = acc_ff[STATE_BITS-1] ? (SAMPLE_BITS'(0) - acc_ff[SAMPLE_BITS-1:0])
                                      : acc_ff[SAMPLE_BITS-1:0];
      lvl_ext  = {{2{mag[SAMPLE_BITS-1]}}, mag};
      env_ext  = {env_ff[ENV_BITS-1], env_ff};
      env_diff = lvl_ext - env_ext;
      if (lvl_ext > env_ext) begin
         env_step = env_diff >>> ATTACK_SHIFT;
      end else begin
         env_step = env_diff >>> RELEASE_SHIFT;
      end
      env_new = env_ext + env_step;
   end

   // gain step toward the capped quotient
   always_comb begin
      if (quotient > {{(DIV_NUM_BITS-GAIN_BITS){1'b0}}, cfg.max_gain}) begin
         want = cfg.max_gain;
      end else begin
         want = quotient[GAIN_BITS-1:0];
      end
      gain_diff = $signed({1'b0, want}) - $signed({1'b0, gain_ff});
      gain_step = gain_diff >>> GAIN_SHIFT;
      gain_new  = $signed({1'b0, gain_ff}) + gain_step;
   end

   assign prod_top = prod_ff[PROD_BITS-1:SAMPLE_BITS-1];

   // next values per operation
   always_comb begin
      d1_in   = d1_ff;
      d2_in   = d2_ff;
      env_in  = env_ff;
      gain_in = gain_ff;
      x_in    = x_ff;
      acc_in  = acc_ff;
      w_in    = w_ff;
      prod_in = prod_ff;
      out_in  = out_ff;
      case (cmd.op)
         OP_LOAD: x_in = req_sample_in;
         OP_M_A1: begin
            prod_in = mul_p;
            acc_in  = x_ext;
         end
         OP_M_A2: begin
            prod_in = mul_p;
            acc_in  = acc_ff - psh;
         end
         OP_W:    w_in = acc_ff - psh;
         OP_M_B0: prod_in = mul_p;
         OP_M_B1: begin
            prod_in = mul_p;
            acc_in  = psh;
         end
         OP_M_B2: begin
            prod_in = mul_p;
            acc_in  = acc_ff + psh;
         end
         OP_BP: begin
            acc_in = acc_ff + psh;
            d2_in  = d1_ff;
            d1_in  = w_ff;
         end
         OP_ENV:     env_in = env_new[ENV_BITS-1:0];
         OP_GAIN:    gain_in = gain_new[GAIN_BITS-1:0];
         OP_M_XG:    prod_in = mul_p;
         OP_M_BOOST: prod_in = mul_p;
         OP_OUT: begin
            // saturate to the signed sample range
            if (prod_ff[PROD_BITS-1] && !(&prod_top)) begin
               out_in = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            end else if (!prod_ff[PROD_BITS-1] && (|prod_top)) begin
               out_in = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            end else begin
               out_in = prod_ff[SAMPLE_BITS-1:0];
            end
         end
         default: begin
            out_in = out_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff   <= '0;
         d2_ff   <= '0;
         env_ff  <= '0;
         gain_ff <= GAIN_BITS'(UNITY_GAIN);
      end else begin
         d1_ff   <= d1_in;
         d2_ff   <= d2_in;
         env_ff  <= env_in;
         gain_ff <= gain_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      acc_ff  <= acc_in;
      w_ff    <= w_in;
      prod_ff <= prod_in;
      out_ff  <= out_in;
   end

   // divide target by envelope for the wanted gain
   sba_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({cfg.target_level, {Q_SHIFT{1'b0}}}),
      .divisor  (env_ff[DIV_DEN_BITS-1:0]),
      .done     (div_done),
      .quotient (quotient)
   );

   assign stat.env_above = $signed(env_ff) > $signed(ENV_BITS'(ENV_FLOOR));
   assign stat.div_done  = div_done;
   assign rsp_sample_out = out_ff;

endmodule

`default_nettype wire

### rtl/sba_csr.sv
// configuration registers behind the apb-style port
// depends on sba_pkg
`default_nettype none

module sba_csr
   import sba_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0]      prdata,
   output logic                          pready,
   output cfg_type                       cfg
);

   cfg_type                 cfg_ff, cfg_in;
   logic [REG_IDX_BITS-1:0] idx;
   logic                    wr_en;

   assign idx   = paddr[CSR_ADDR_BITS-1:2];
   assign wr_en = psel & penable & pwrite;

   // register write decode, low bits kept
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_COEF_B0:      cfg_in.coef_b0      = pwdata[COEF_BITS-1:0];
            REG_COEF_B1:      cfg_in.coef_b1      = pwdata[COEF_BITS-1:0];
            REG_COEF_B2:      cfg_in.coef_b2      = pwdata[COEF_BITS-1:0];
            REG_COEF_A1:      cfg_in.coef_a1      = pwdata[COEF_BITS-1:0];
            REG_COEF_A2:      cfg_in.coef_a2      = pwdata[COEF_BITS-1:0];
            REG_TARGET_LEVEL: cfg_in.target_level = pwdata[TARGET_BITS-1:0];
            REG_MAX_GAIN:     cfg_in.max_gain     = pwdata[GAIN_BITS-1:0];
            REG_OUT_BOOST:    cfg_in.out_boost    = pwdata[BOOST_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_b0      <= RST_COEF_B0;
         cfg_ff.coef_b1      <= RST_COEF_B1;
         cfg_ff.coef_b2      <= RST_COEF_B2;
         cfg_ff.coef_a1      <= RST_COEF_A1;
         cfg_ff.coef_a2      <= RST_COEF_A2;
         cfg_ff.target_level <= RST_TARGET_LEVEL;
         cfg_ff.max_gain     <= RST_MAX_GAIN;
         cfg_ff.out_boost    <= RST_OUT_BOOST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (idx)
         REG_COEF_B0:      prdata = CSR_DATA_BITS'(cfg_ff.coef_b0);
         REG_COEF_B1:      prdata = CSR_DATA_BITS'(cfg_ff.coef_b1);
         REG_COEF_B2:      prdata = CSR_DATA_BITS'(cfg_ff.coef_b2);
         REG_COEF_A1:      prdata = CSR_DATA_BITS'(cfg_ff.coef_a1);
         REG_COEF_A2:      prdata = CSR_DATA_BITS'(cfg_ff.coef_a2);
         REG_TARGET_LEVEL: prdata = CSR_DATA_BITS'(cfg_ff.target_level);
         REG_MAX_GAIN:     prdata = CSR_DATA_BITS'(cfg_ff.max_gain);
         REG_OUT_BOOST:    prdata = CSR_DATA_BITS'(cfg_ff.out_boost);
         default:          prdata = '0;
      endcase
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

`default_nettype wire

### rtl/sba_ctrl.sv
// controller: sequences the datapath through one item and owns the handshakes
// depends on sba_pkg
`default_nettype none

module sba_ctrl
   import sba_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_M_A1    = 4'd1;
   localparam logic [3:0] ST_M_A2    = 4'd2;
   localparam logic [3:0] ST_W       = 4'd3;
   localparam logic [3:0] ST_M_B0    = 4'd4;
   localparam logic [3:0] ST_M_B1    = 4'd5;
   localparam logic [3:0] ST_M_B2    = 4'd6;
   localparam logic [3:0] ST_BP      = 4'd7;
   localparam logic [3:0] ST_ENV     = 4'd8;
   localparam logic [3:0] ST_CHK     = 4'd9;
   localparam logic [3:0] ST_DIV     = 4'd10;
   localparam logic [3:0] ST_GAIN    = 4'd11;
   localparam logic [3:0] ST_M_XG    = 4'd12;
   localparam logic [3:0] ST_M_BOOST = 4'd13;
   localparam logic [3:0] ST_OUT     = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // next state and command
   always_comb begin
      state_in      = state_ff;
      cmd.op        = OP_NOP;
      cmd.div_start = 1'b0;
      // a waiting result clears once taken
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_M_A1;
            end
         end
         ST_M_A1: begin
            cmd.op   = OP_M_A1;
            state_in = ST_M_A2;
         end
         ST_M_A2: begin
            cmd.op   = OP_M_A2;
            state_in = ST_W;
         end
         ST_W: begin
            cmd.op   = OP_W;
            state_in = ST_M_B0;
         end
         ST_M_B0: begin
            cmd.op   = OP_M_B0;
            state_in = ST_M_B1;
         end
         ST_M_B1: begin
            cmd.op   = OP_M_B1;
            state_in = ST_M_B2;
         end
         ST_M_B2: begin
            cmd.op   = OP_M_B2;
            state_in = ST_BP;
         end
         ST_BP: begin
            cmd.op   = OP_BP;
            state_in = ST_ENV;
         end
         ST_ENV: begin
            cmd.op   = OP_ENV;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            // quiet envelope holds the gain
            if (stat.env_above) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_M_XG;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            cmd.op   = OP_GAIN;
            state_in = ST_M_XG;
         end
         ST_M_XG: begin
            cmd.op   = OP_M_XG;
            state_in = ST_M_BOOST;
         end
         ST_M_BOOST: begin
            cmd.op   = OP_M_BOOST;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // wait until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### rtl/speech_band_agc_unit.sv
// Speech band automatic gain control, top level.
// Depends on sba_pkg, sba_csr, sba_ctrl and sba_dpath.
//
// Input channel req_: one signed sample per item on req_sample_in, taken when
// req_valid is high and req_stall is low. Result channel rsp_: one gain
// controlled sample per item on rsp_sample_out, taken when rsp_valid is high
// and rsp_stall is low. Configuration goes through the apb-style port (psel,
// penable, pwrite, paddr, pwdata, prdata, pready), register i at byte 4*i;
// write it only while no item is in flight.
//
// One item is worked at a time. An item runs through seven passes of the
// shared multiplier. When the envelope is at or below the floor the gain is
// held; when it is above, the gain is updated after the serial divider, two
// quotient bits per cycle, gives the wanted gain. req_stall is high while an
// item is in work. The result sits in an output register, so the next item
// is taken while it waits; if the receiver stalls, a second result holds in
// the datapath until the output register frees. Synchronous reset clears the
// filter state and envelope, sets the gain to unity and loads the register
// defaults.
`default_nettype none

module speech_band_agc_unit
   import sba_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [SAMPLE_BITS-1:0]   req_sample_in,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [SAMPLE_BITS-1:0]        rsp_sample_out,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0]      prdata,
   output logic                          pready
);

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   // configuration registers
   sba_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer
   sba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // arithmetic
   sba_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .cfg            (cfg),
      .req_sample_in  (req_sample_in),
      .stat           (stat),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

`default_nettype wire
